// ===== hw/rtl/cgl_pkg.sv =====
package cgl_pkg;

  localparam int unsigned MaxStops = 8;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned PosW     = 16;
  localparam int unsigned ColorW   = 32;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic        op;
    logic [2:0]  stop_slot;
    logic [15:0] position;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [7:0]  in_alpha;
  } cgl_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       clamped;
  } cgl_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic wr_stop;    // write the stop slot
    logic rd_first;   // read slot 0
    logic rd_last;    // read slot n-1
    logic rd_scan;    // read slot scan index
    logic cap_prev;   // latch read as previous stop
    logic cap_cur;    // latch read as current stop
    logic scan_inc;   // advance scan index
    logic div_init;   // start ratio division
    logic div_step;   // one quotient bit
    logic blend;      // blend one channel
    logic emit_black; // output opaque black
    logic emit_prev;  // output prev stop color, clamped
    logic emit_blend; // output blended color
  } cgl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic n_zero;
    logic n_one;
    logic q_le_prev;  // q <= prev position
    logic q_ge_cur;   // q >= cur position
    logic bracket;    // prev < q <= cur
    logic scan_last;  // scan index at n-1
    logic div_done;
    logic blend_done;
  } cgl_sts_t;

endpackage

// ===== hw/rtl/cgl_ram.sv =====
module cgl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/cgl_datapath.sv =====
module cgl_datapath import cgl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CountW-1:0]     cfg_wdata_i,
  input  cgl_in_t               in_i,
  input  cgl_cmd_t              cmd_i,
  output cgl_sts_t              sts_o,
  output logic                  valid_o,
  output cgl_out_t              res_o
);
  logic [CountW-1:0] count_q;
  cgl_in_t           item_q;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic [SlotW-1:0]  raddr;
  logic [SlotW-1:0]  last_idx;
  logic [PosW-1:0]   pos_rd;
  logic [ColorW-1:0] col_rd;
  logic [PosW-1:0]   p0_q, p1_q;
  logic [ColorW-1:0] c0_q, c1_q;
  logic [PosW:0]     rem_q;
  logic [PosW:0]     quo_q;
  logic [PosW:0]     den;
  logic [PosW-1:0]   dvd;
  logic [PosW+1:0]   rem_sh;
  logic [4:0]        dcnt_q;
  logic [1:0]        ch_q;
  logic [ColorW-1:0] mix_q;
  logic [7:0]        ca, cb;
  logic [PosW+8:0]   prod;
  logic [7:0]        ch_res;
  logic              valid_q;
  cgl_out_t          res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) count_q <= cfg_wdata_i;
      valid_q <= cmd_i.emit_black | cmd_i.emit_prev | cmd_i.emit_blend;
      idx_q   <= idx_d;
    end
  end

  // effective count clamped to the table size
  always_comb begin
    if (count_q > CountW'(MaxStops)) last_idx = SlotW'(MaxStops - 1);
    else last_idx = SlotW'(count_q - 1'b1);
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) idx_d = SlotW'(1);
    else if (cmd_i.scan_inc) idx_d = idx_q + 1'b1;
  end

  always_comb begin
    raddr = idx_q;
    if (cmd_i.rd_first) raddr = '0;
    else if (cmd_i.rd_last) raddr = last_idx;
    else if (cmd_i.rd_scan) raddr = idx_q;
  end

  cgl_ram #(.Width(PosW), .Depth(MaxStops)) u_pos_ram (
    .clk_i, .we_i(cmd_i.wr_stop), .waddr_i(item_q.stop_slot),
    .wdata_i(item_q.position), .raddr_i(raddr), .rdata_o(pos_rd)
  );
  cgl_ram #(.Width(ColorW), .Depth(MaxStops)) u_col_ram (
    .clk_i, .we_i(cmd_i.wr_stop), .waddr_i(item_q.stop_slot),
    .wdata_i({item_q.in_alpha, item_q.in_blue, item_q.in_green, item_q.in_red}),
    .raddr_i(raddr), .rdata_o(col_rd)
  );

  assign den    = {1'b0, p1_q - p0_q};
  assign dvd    = item_q.position - p0_q;
  assign rem_sh = {rem_q, quo_q[PosW]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.cap_prev) begin
      p0_q <= pos_rd;
      c0_q <= col_rd;
    end
    if (cmd_i.cap_cur) begin
      p1_q <= pos_rd;
      c1_q <= col_rd;
    end
    // restoring division of (q-p0)<<16 by (p1-p0), 17 quotient bits
    // the upper quotient bits are zero, so start from (q-p0)>>1
    if (cmd_i.div_init) begin
      rem_q  <= {2'b00, dvd[PosW-1:1]};
      quo_q  <= {dvd[0], {PosW{1'b0}}};
      dcnt_q <= '0;
      ch_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem_q <= (PosW+1)'(rem_sh - {1'b0, den});
        quo_q <= {quo_q[PosW-1:0], 1'b1};
      end else begin
        rem_q <= rem_sh[PosW:0];
        quo_q <= {quo_q[PosW-1:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.blend) begin
      mix_q <= {ch_res, mix_q[ColorW-1:8]};
      ch_q  <= ch_q + 1'b1;
    end
    if (cmd_i.emit_black) res_q <= '{8'd0, 8'd0, 8'd0, 8'd255, 1'b1};
    else if (cmd_i.emit_prev)
      res_q <= '{c0_q[7:0], c0_q[15:8], c0_q[23:16], c0_q[31:24], 1'b1};
    else if (cmd_i.emit_blend)
      res_q <= '{mix_q[7:0], mix_q[15:8], mix_q[23:16], mix_q[31:24], 1'b0};
  end

  // a + (b-a)*ratio >> 16 equals the two-product form; done as one signed product
  always_comb begin
    ca   = 8'(c0_q >> {ch_q, 3'b000});
    cb   = 8'(c1_q >> {ch_q, 3'b000});
    prod = (PosW+9)'($signed({1'b0, ca, 16'h0}) +
           $signed({1'b0, cb} - {1'b0, ca}) * $signed({1'b0, quo_q}));
    ch_res = prod[23:16];
  end

  assign sts_o.is_lookup  = item_q.op == OpLookup;
  assign sts_o.n_zero     = count_q == '0;
  assign sts_o.n_one      = count_q == CountW'(1);
  assign sts_o.q_le_prev  = item_q.position <= p0_q;
  assign sts_o.q_ge_cur   = item_q.position >= p1_q;
  assign sts_o.bracket    = (p0_q < item_q.position) && (item_q.position <= p1_q);
  assign sts_o.scan_last  = idx_q == last_idx;
  assign sts_o.div_done   = dcnt_q == 5'd17;
  assign sts_o.blend_done = ch_q == 2'd3;

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

// ===== hw/rtl/cgl_ctrl.sv =====
module cgl_ctrl import cgl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  cgl_sts_t sts_i,
  output cgl_cmd_t cmd_o,
  output logic     busy_o
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StRdF   = 4'd2;
  localparam logic [3:0] StRdL   = 4'd3;
  localparam logic [3:0] StChkF  = 4'd4;
  localparam logic [3:0] StChkL  = 4'd5;
  localparam logic [3:0] StRdS   = 4'd6;
  localparam logic [3:0] StCapS  = 4'd7;
  localparam logic [3:0] StTest  = 4'd8;
  localparam logic [3:0] StDiv   = 4'd9;
  localparam logic [3:0] StBlend = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;
  localparam logic [3:0] StDone  = 4'd12;
  localparam logic [3:0] StLast  = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDec;
        end
      end
      StDec: begin
        if (!sts_i.is_lookup) begin
          cmd_o.wr_stop = 1'b1;
          state_d       = StDone;
        end else if (sts_i.n_zero) begin
          cmd_o.emit_black = 1'b1;
          state_d          = StDone;
        end else begin
          cmd_o.rd_first = 1'b1;
          state_d        = StRdF;
        end
      end
      StRdF: begin
        cmd_o.cap_prev = 1'b1;
        cmd_o.rd_last  = 1'b1;
        state_d        = StRdL;
      end
      StRdL: begin
        cmd_o.cap_cur = 1'b1;
        state_d       = StChkF;
      end
      StChkF: begin
        if (sts_i.n_one || sts_i.q_le_prev) begin
          cmd_o.emit_prev = 1'b1;
          state_d         = StDone;
        end else if (sts_i.q_ge_cur) begin
          state_d = StChkL;
        end else begin
          state_d = StRdS;
        end
      end
      StChkL: begin
        // reuse prev path: copy last stop into prev by reading it again
        cmd_o.rd_last = 1'b1;
        state_d       = StOut;
      end
      StOut: begin
        cmd_o.cap_prev = 1'b1;
        state_d        = StLast;
      end
      StLast: begin
        cmd_o.emit_prev = 1'b1;
        state_d         = StDone;
      end
      StRdS: begin
        // idx_q (starts at 1) addresses the scan read
        cmd_o.rd_scan = 1'b1;
        state_d       = StCapS;
      end
      StCapS: begin
        cmd_o.cap_cur = 1'b1;
        state_d       = StTest;
      end
      StTest: begin
        if (sts_i.bracket) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end else if (sts_i.scan_last) begin
          state_d = StChkL;
        end else begin
          cmd_o.cap_prev = 1'b1;
          cmd_o.scan_inc = 1'b1;
          state_d        = StRdS;
        end
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StBlend;
        else cmd_o.div_step = 1'b1;
      end
      StBlend: begin
        cmd_o.blend = 1'b1;
        if (sts_i.blend_done) state_d = StDone;
      end
      StDone: begin
        if (state_q == StDone && !cmd_o.emit_blend) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StBlend && sts_i.blend_done) begin
      state_d = StDone;
    end
  end

  assign busy_o = state_q != StIdle;

  property p_emit_onehot;
    @(posedge clk_i) disable iff (!rst_ni)
      $onehot0({cmd_o.emit_black, cmd_o.emit_prev, cmd_o.emit_blend});
  endproperty
  a_emit_onehot: assert property (p_emit_onehot) else $error("two emits");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !cmd_o.wr_stop && !cmd_o.div_step)
    else $error("datapath command while idle");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy_o) else $error("not busy after load");
endmodule

// ===== hw/rtl/color_gradient_lookup.sv =====
// result paths: opaque black with no stops, clamped at first, clamped at last,
// blended in segment i, or clamped at last when no segment brackets the query
// lookup cost set by the stop scan, the divider for the
// 17-bit ratio and one shared multiplier blending four channels in turn
// throughput: one transaction at a time, busy high for each write and each lookup
// reset: stop_count clears to 0, stop table undefined until written; the receiver cannot stall
module color_gradient_lookup import cgl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cgl_in_t           item_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  output logic              result_valid_o,
  output cgl_out_t          result_o
);
  cgl_cmd_t cmd;
  cgl_sts_t sts;
  logic     dp_valid;
  logic     emit_blend_q;

  // controller sequences decode, scan, divide and blend
  cgl_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  // the blended color is emitted right after the last channel blend
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_blend_q <= 1'b0;
    else emit_blend_q <= cmd.blend && sts.blend_done;
  end

  cgl_cmd_t dp_cmd;
  always_comb begin
    dp_cmd            = cmd;
    dp_cmd.emit_blend = emit_blend_q;
  end

  cgl_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i(item_i), .cmd_i(dp_cmd),
    .sts_o(sts), .valid_o(dp_valid), .res_o(result_o)
  );

  assign result_valid_o = dp_valid;
endmodule

// ===== test/tb_color_gradient_lookup.sv =====
`timescale 1ns / 100ps

module tb_color_gradient_lookup;
  import cgl_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  cgl_in_t           item_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              result_valid_o;
  cgl_out_t          result_o;

  color_gradient_lookup dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state: our own copy of the stop table and count
  logic [PosW-1:0]   grad_pos [MaxStops];
  logic [ColorW-1:0] grad_rgba[MaxStops];
  logic [CountW-1:0] grad_count;
  cgl_out_t          color_queue[$];

  int unsigned n_errors  = 0;
  int unsigned n_lookups = 0;
  int unsigned n_blended = 0;
  int unsigned idle_cnt  = 0;
  localparam int unsigned WatchdogLimit = 4000;

  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b,
                                             logic [16:0] ratio);
    logic [31:0] acc;
    acc = a * (32'd65536 - ratio) + b * ratio;
    return acc[23:16];
  endfunction

  function automatic cgl_out_t color_of(logic [ColorW-1:0] c, logic flag);
    cgl_out_t r;
    r.out_red   = c[7:0];
    r.out_green = c[15:8];
    r.out_blue  = c[23:16];
    r.out_alpha = c[31:24];
    r.clamped   = flag;
    return r;
  endfunction

  // compute the expected color for a query position
  function automatic cgl_out_t gradient_color(logic [PosW-1:0] q);
    int unsigned n;
    logic [31:0] ratio;
    logic [ColorW-1:0] c0, c1, mix;
    n = (grad_count > MaxStops) ? MaxStops : grad_count;
    if (n == 0) return color_of(32'hFF00_0000, 1'b1);
    if (n == 1 || q <= grad_pos[0]) return color_of(grad_rgba[0], 1'b1);
    if (q >= grad_pos[n-1]) return color_of(grad_rgba[n-1], 1'b1);
    for (int i = 1; i < n; i++) begin
      if (grad_pos[i-1] < q && q <= grad_pos[i]) begin
        ratio = ((32'(q) - grad_pos[i-1]) << 16) / (32'(grad_pos[i]) - grad_pos[i-1]);
        c0 = grad_rgba[i-1];
        c1 = grad_rgba[i];
        for (int s = 0; s < 4; s++)
          mix[s*8 +: 8] = mix_channel(c0[s*8 +: 8], c1[s*8 +: 8], ratio[16:0]);
        return color_of(mix, 1'b0);
      end
    end
    // unsorted table: nothing brackets q
    return color_of(grad_rgba[n-1], 1'b1);
  endfunction

  // random gap: mostly none or short, now and then long
  task automatic idle_gap();
    int unsigned g;
    g = $urandom_range(0, 99);
    if (g < 50) g = 0;
    else if (g < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    repeat (g) @(negedge clk_i);
  endtask

  // drive one transaction and wait until it is taken
  task automatic send_item(cgl_in_t it);
    start  = 1'b1;
    item_i = it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    if (it.op == OpWrite) begin
      grad_pos[it.stop_slot]  = it.position;
      grad_rgba[it.stop_slot] = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
    end else begin
      color_queue.push_back(gradient_color(it.position));
      n_lookups++;
    end
    start = 1'b0;
    idle_gap();
  endtask

  task automatic write_stop(logic [2:0] slot, logic [15:0] p, logic [31:0] c);
    cgl_in_t it;
    it = '{OpWrite, slot, p, c[7:0], c[15:8], c[23:16], c[31:24]};
    send_item(it);
  endtask

  task automatic lookup(logic [15:0] q);
    cgl_in_t it;
    it = '0;
    it.op = OpLookup;
    it.stop_slot = 3'($urandom);
    it.position = q;
    {it.in_red, it.in_green, it.in_blue, it.in_alpha} = $urandom;
    send_item(it);
  endtask

  // only while idle: drain results, then let the block settle
  task automatic set_stop_count(logic [CountW-1:0] v);
    while (color_queue.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    grad_count = v;
  endtask

  // fill slots 0..n-1 with sorted random stops; ties now and then
  task automatic fill_sorted(int unsigned n, logic wide);
    logic [15:0] p;
    int unsigned step;
    p = wide ? 16'($urandom_range(0, 2000)) : 16'($urandom_range(0, 100));
    for (int i = 0; i < n; i++) begin
      write_stop(3'(i), p, $urandom);
      if ($urandom_range(0, 9) != 0) begin
        step = wide ? $urandom_range(1, 65535 / 8) : $urandom_range(1, 20);
        p = (32'(p) + step > 65535) ? 16'hFFFF : 16'(32'(p) + step);
      end
    end
  endtask

  // result checker: sampled at the rising edge
  always @(posedge clk_i) begin
    cgl_out_t exp_c;
    if (rst_ni && result_valid_o) begin
      if (color_queue.size() == 0) begin
        $error("result with no pending lookup");
        n_errors++;
      end else begin
        exp_c = color_queue.pop_front();
        if (exp_c.clamped == 1'b0) n_blended++;
        if (result_o.out_red !== exp_c.out_red) begin
          $error("out_red exp %0d got %0d", exp_c.out_red, result_o.out_red); n_errors++;
        end
        if (result_o.out_green !== exp_c.out_green) begin
          $error("out_green exp %0d got %0d", exp_c.out_green, result_o.out_green); n_errors++;
        end
        if (result_o.out_blue !== exp_c.out_blue) begin
          $error("out_blue exp %0d got %0d", exp_c.out_blue, result_o.out_blue); n_errors++;
        end
        if (result_o.out_alpha !== exp_c.out_alpha) begin
          $error("out_alpha exp %0d got %0d", exp_c.out_alpha, result_o.out_alpha); n_errors++;
        end
        if (result_o.clamped !== exp_c.clamped) begin
          $error("clamped exp %0d got %0d", exp_c.clamped, result_o.clamped); n_errors++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted transaction of either kind
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // directed: empty table, single stop, clamps, ties, extremes
  task automatic test_directed();
    lookup(16'h0000);                       // no stops: opaque black
    lookup(16'hFFFF);
    write_stop(3'd0, 16'h8000, 32'h11223344);
    set_stop_count(4'd1);
    lookup(16'h0000);                       // one stop
    lookup(16'hFFFF);
    write_stop(3'd1, 16'hFFFF, 32'hFFFFFFFF);
    write_stop(3'd0, 16'h0000, 32'h00000000);
    set_stop_count(4'd2);
    lookup(16'h0000);                       // at first
    lookup(16'hFFFF);                       // at last
    lookup(16'h0001);
    lookup(16'hFFFE);
    lookup(16'h8000);
    write_stop(3'd2, 16'hFFFF, 32'h12345678); // equal positions, the last stop wins
    write_stop(3'd3, 16'hFFFF, 32'hA5A5A5A5);
    set_stop_count(4'd4);
    lookup(16'hFFFF);
    lookup(16'h7FFF);
    // unsorted table
    write_stop(3'd1, 16'h0010, 32'hCAFEF00D);
    write_stop(3'd2, 16'h0008, 32'h0BADBEEF);
    write_stop(3'd3, 16'h4000, 32'h5A5A5A5A);
    lookup(16'h000C);
    lookup(16'h3000);
  endtask

  // count above table size acts as full table
  task automatic test_count_over();
    fill_sorted(8, 1'b1);
    for (int c = 8; c <= 15; c++) begin
      set_stop_count(4'(c));
      repeat (4) lookup(16'($urandom));
    end
  endtask

  // random gradients and lookups across count settings
  task automatic test_random();
    int unsigned n;
    logic wide;
    for (int round = 0; round < 100; round++) begin
      n = $urandom_range(0, 8);
      wide = ($urandom_range(0, 3) != 0);
      set_stop_count(4'(n));
      if ($urandom_range(0, 9) == 0) begin
        // broken sequence: unsorted stops, all slots written
        for (int i = 0; i < 8; i++) write_stop(3'(i), 16'($urandom), $urandom);
      end else begin
        fill_sorted(8, wide);
      end
      repeat (12) begin
        if ($urandom_range(0, 4) == 0) lookup(16'($urandom));
        else if (wide) lookup(16'($urandom_range(0, 65535)));
        else lookup(16'($urandom_range(0, 200)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MaxStops; i++) begin
      grad_pos[i] = '0;
      grad_rgba[i] = '0;
    end
    grad_count = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_count_over();
    test_random();
    set_stop_count(4'd0);
    while (color_queue.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("covered %0d lookups (%0d interpolated) over counts 0 to 15",
             n_lookups, n_blended);
    if (n_errors == 0 && color_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== color_gradient_lookup.f =====
hw/rtl/cgl_pkg.sv
hw/rtl/cgl_ram.sv
hw/rtl/cgl_datapath.sv
hw/rtl/cgl_ctrl.sv
hw/rtl/color_gradient_lookup.sv
test/tb_color_gradient_lookup.sv
